// File: rtl/image_crc32_word_checker_defines.svh
// assertion macros for the image crc-32 word checker
// no dependencies, included by the top level
`ifndef IMAGE_CRC32_WORD_CHECKER_DEFINES_SVH
`define IMAGE_CRC32_WORD_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ICRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icrc assertion failed");
`define ICRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icrc assertion failed");
`else
`define ICRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ICRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/icrc_pkg.sv
// shared types and constants for the image crc-32 word checker
// no dependencies
package icrc_pkg;

    localparam int CRC_W  = 32;
    localparam int DATA_W = 16;
    localparam int ADDR_W = 4;

    typedef logic [CRC_W-1:0]  t_crc;
    typedef logic [DATA_W-1:0] t_data;

    typedef enum logic [1:0] {
        REG_POLY     = 2'd0,
        REG_INIT     = 2'd1,
        REG_OUT_MASK = 2'd2,
        REG_EXPECTED = 2'd3
    } t_reg_idx;

    localparam t_crc POLY_RST     = 32'hEDB8_8320;
    localparam t_crc INIT_RST     = 32'hFFFF_FFFF;
    localparam t_crc OUT_MASK_RST = 32'hFFFF_FFFF;
    localparam t_crc EXPECTED_RST = 32'h0000_0000;

endpackage

// File: rtl/image_crc32_word_checker.sv
// image crc-32 word checker: an accepted word goes to the input register and a run's
// result to the result register; one word accepted every cycle while o_in_stall is low
// a word marked last may wait only while the result register is held by a stall
// synchronous active-low reset clears control and loads register defaults;
// the running crc is not reset, the first word of a run loads initial_value
// depends on icrc_pkg, icrc_word_step and image_crc32_word_checker_defines.svh
`include "image_crc32_word_checker_defines.svh"

module image_crc32_word_checker #(
    parameter int WORD_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [icrc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,

    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  icrc_pkg::t_data          i_data_word,
    input  logic                     i_last_word,

    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output icrc_pkg::t_crc           o_crc_value,
    output logic                     o_crc_match
);
    import icrc_pkg::*;

    t_crc     r_poly;
    t_crc     r_init;
    t_crc     r_out_mask;
    t_crc     r_expected;
    t_reg_idx w_reg_idx;
    logic     w_cfg_wr;

    logic     r_in_valid;
    t_data    r_word;
    logic     r_last;

    t_crc     r_crc;
    logic     r_run_start;

    logic     r_out_valid;
    t_crc     r_crc_value;
    logic     r_crc_match;

    logic     w_in_take;
    logic     w_out_free;
    logic     w_s1_move;
    t_crc     w_crc_base;
    t_crc     n_crc;
    t_crc     w_crc_final;

    // config port
    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly     <= POLY_RST;
            r_init     <= INIT_RST;
            r_out_mask <= OUT_MASK_RST;
            r_expected <= EXPECTED_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_POLY:     r_poly     <= pwdata;
                REG_INIT:     r_init     <= pwdata;
                REG_OUT_MASK: r_out_mask <= pwdata;
                REG_EXPECTED: r_expected <= pwdata;
                default:      r_poly     <= r_poly;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_POLY:     prdata = r_poly;
            REG_INIT:     prdata = r_init;
            REG_OUT_MASK: prdata = r_out_mask;
            REG_EXPECTED: prdata = r_expected;
            default:      prdata = '0;
        endcase
    end

    // flow control
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_move  = r_in_valid && (!r_last || w_out_free);
    assign o_in_stall = r_in_valid && !w_s1_move;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_word <= i_data_word;
            r_last <= i_last_word;
        end
    end

    // crc update
    assign w_crc_base = r_run_start ? r_init : r_crc;

    icrc_word_step #(
        .WORD_BITS (WORD_BITS)
    ) u_step (
        .i_crc  (w_crc_base),
        .i_word (r_word),
        .i_poly (r_poly),
        .o_crc  (n_crc)
    );

    assign w_crc_final = n_crc ^ r_out_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_start <= 1'b1;
        end else if (w_s1_move) begin
            r_run_start <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_crc <= n_crc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move && r_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move && r_last) begin
            r_crc_value <= w_crc_final;
            r_crc_match <= (w_crc_final == r_expected);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_crc_value;
    assign o_crc_match = r_crc_match;

    // checks
    `ICRC_ASSERT_NEXT(a_run_restart, i_clk, i_rst_n, w_s1_move && r_last, r_run_start && r_out_valid)
    `ICRC_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, r_out_valid && i_out_stall, !(w_s1_move && r_last))
    `ICRC_ASSERT_NOW(a_stall_held, i_clk, i_rst_n, o_in_stall, r_in_valid && r_last)

endmodule

// File: rtl/icrc_word_step.sv
// unrolled reflected crc-32 update over one data word, lsb first
// depends on icrc_pkg
module icrc_word_step #(
    parameter int WORD_BITS = 16
) (
    input  icrc_pkg::t_crc  i_crc,
    input  icrc_pkg::t_data i_word,
    input  icrc_pkg::t_crc  i_poly,
    output icrc_pkg::t_crc  o_crc
);
    import icrc_pkg::*;

    logic [CRC_W-1:0] w_word_ext;

    assign w_word_ext = {{(CRC_W-DATA_W){1'b0}}, i_word};

    always_comb begin
        t_crc c;
        c = i_crc;
        for (int n = 0; n < WORD_BITS; n++) begin
            if (c[0] ^ w_word_ext[n]) begin
                c = (c >> 1) ^ i_poly;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

// File: verif/image_crc32_word_checker_tb.sv
// testbench for image_crc32_word_checker: random and directed image word runs,
// apb register setup between phases, results checked against a crc predictor
// depends on icrc_pkg and the image_crc32_word_checker rtl
module image_crc32_word_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import icrc_pkg::*;

    localparam int STEP_BITS   = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 750;

    typedef struct {
        t_crc value;
        logic match;
    } t_final;

    class image_crc_tracker;
        t_crc poly;
        t_crc init_val;
        t_crc out_mask;
        t_crc expected;
        t_crc running;
        bit run_start;
        t_final finals_due[$];
        int unsigned mismatches;

        function new();
            poly       = POLY_RST;
            init_val   = INIT_RST;
            out_mask   = OUT_MASK_RST;
            expected   = EXPECTED_RST;
            running    = '0;
            run_start  = 1'b1;
            mismatches = 0;
        endfunction

        function void set_reg(t_reg_idx idx, t_crc val);
            case (idx)
                REG_POLY:     poly = val;
                REG_INIT:     init_val = val;
                REG_OUT_MASK: out_mask = val;
                REG_EXPECTED: expected = val;
                default: ;
            endcase
        endfunction

        function t_crc crc_word_update(t_crc crc, t_data word);
            logic d;
            for (int n = 0; n < STEP_BITS; n++) begin
                d = (n < DATA_W) ? word[n] : 1'b0;
                if (crc[0] ^ d) begin
                    crc = (crc >> 1) ^ poly;
                end else begin
                    crc = crc >> 1;
                end
            end
            return crc;
        endfunction

        // final value a run of these words would give from the current state
        function t_crc final_of(input t_data words[$]);
            t_crc crc;
            crc = run_start ? init_val : running;
            foreach (words[k]) crc = crc_word_update(crc, words[k]);
            return crc ^ out_mask;
        endfunction

        function void take_word(t_data word, logic last);
            t_final f;
            running   = crc_word_update(run_start ? init_val : running, word);
            run_start = 1'b0;
            if (last) begin
                f.value = running ^ out_mask;
                f.match = (f.value == expected);
                finals_due.push_back(f);
                run_start = 1'b1;
            end
        endfunction

        task report_mismatch(string what, t_crc got, t_crc want);
            $display("mismatch %s: got %h, predicted %h", what, got, want);
            mismatches++;
        endtask

        task check_final(t_crc value, logic match);
            t_final f;
            if (finals_due.size() == 0) begin
                report_mismatch("result with no transaction pending", value, '0);
            end else begin
                f = finals_due.pop_front();
                if (value !== f.value) report_mismatch("crc_value", value, f.value);
                if (match !== f.match) report_mismatch("crc_match", t_crc'(match), t_crc'(f.match));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    t_data       i_data_word;
    logic        i_last_word;
    logic        o_out_valid;
    logic        i_out_stall;
    t_crc        o_crc_value;
    logic        o_crc_match;

    image_crc_tracker tracker = new();
    int unsigned words_sent = 0;
    int unsigned cycle_count = 0;
    bit calm = 1'b0;

    image_crc32_word_checker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_word (i_data_word),
        .i_last_word (i_last_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_crc_value (o_crc_value),
        .o_crc_match (o_crc_match)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("image_crc32_word_checker test failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall = !calm && ($urandom_range(99) < 12);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_final(o_crc_value, o_crc_match);
        end
    end

    // entered and left at a falling edge
    task send_word(t_data word, logic last);
        while (!calm && $urandom_range(99) < 12) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_data_word = word;
        i_last_word = last;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_word(word, last);
        words_sent++;
        calm = (words_sent >= 300 && words_sent < 450);
        @(negedge i_clk);
    endtask

    task send_run(input t_data words[$]);
        foreach (words[k]) send_word(words[k], k == words.size() - 1);
    endtask

    task settle();
        i_in_valid = 1'b0;
        while (tracker.finals_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task apb_write(t_reg_idx idx, t_crc val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function t_crc pick_value();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_data words[$];
        t_crc p;
        t_crc iv;
        t_crc m;
        int phase;
        int n_runs;
        int len;

        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_in_valid  = 1'b0;
        i_data_word = '0;
        i_last_word = 1'b0;
        i_out_stall = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset settings, single-word and multi-word runs
        words = '{16'h0000};
        send_run(words);
        words = '{16'hFFFF};
        send_run(words);
        words = '{16'h0001, 16'h8000, 16'hFFFF};
        send_run(words);
        words = '{16'hA5A5, 16'h5A5A, 16'h0000};
        send_run(words);
        settle();
        words = '{16'h1234};
        apb_write(REG_EXPECTED, tracker.final_of(words));
        send_run(words);
        // registers rewritten in the middle of a run
        send_word(16'hBEEF, 1'b0);
        settle();
        apb_write(REG_INIT, '0);
        apb_write(REG_POLY, 32'h82F6_3B78);
        send_word(16'hCAFE, 1'b1);
        settle();
        apb_write(REG_POLY, '0);
        apb_write(REG_OUT_MASK, '0);
        apb_write(REG_EXPECTED, '0);
        words = '{16'h0000};
        send_run(words);
        words = '{16'hFFFF};
        send_run(words);
        settle();
        apb_write(REG_POLY, '1);
        apb_write(REG_INIT, '1);
        apb_write(REG_OUT_MASK, '1);
        apb_write(REG_EXPECTED, '1);
        words = '{16'hFFFF};
        send_run(words);
        words = '{16'h0000};
        send_run(words);

        phase = 0;
        while (words_sent < RANDOM_WORDS + 15) begin
            settle();
            case (phase)
                0: begin p = '0; iv = '0; m = '0; end
                1: begin p = '1; iv = '1; m = '1; end
                2: begin p = POLY_RST; iv = INIT_RST; m = OUT_MASK_RST; end
                default: begin p = pick_value(); iv = pick_value(); m = pick_value(); end
            endcase
            apb_write(REG_POLY, p);
            apb_write(REG_INIT, iv);
            apb_write(REG_OUT_MASK, m);
            words.delete();
            if ($urandom_range(2) == 0) begin
                // run whose final value is made to match the stored crc
                len = $urandom_range(1, 8);
                repeat (len) words.push_back(t_data'($urandom_range(0, 65535)));
                apb_write(REG_EXPECTED, tracker.final_of(words));
                send_run(words);
            end else begin
                apb_write(REG_EXPECTED, pick_value());
            end
            n_runs = $urandom_range(2, 8);
            repeat (n_runs) begin
                words.delete();
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
                repeat (len) words.push_back(t_data'($urandom_range(0, 65535)));
                send_run(words);
            end
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 4)) send_word(t_data'($urandom_range(0, 65535)), 1'b0);
            end
            phase++;
        end
        send_word(t_data'($urandom_range(0, 65535)), 1'b1);
        settle();
        repeat (10) @(negedge i_clk);

        if (tracker.mismatches == 0 && tracker.finals_due.size() == 0) begin
            $display("image_crc32_word_checker test passed");
        end else begin
            $display("image_crc32_word_checker test failed");
        end
        $finish;
    end
endmodule
